// ===== design/tlc_pkg.sv =====
// Shared types and constants of the trajectory limit checker.
package tlc_pkg;

  localparam int TimeW   = 16;
  localparam int SampleW = 16;
  localparam int LimitW  = 15;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;

  // Shared multiplier operand and product widths
  localparam int MulAW = 33;
  localparam int MulBW = 17;
  localparam int MulPW = MulAW + MulBW;

  // Derived datapath widths
  localparam int DtW      = TimeW + 1;
  localparam int LatW     = 47;
  localparam int LatDiffW = LatW + 1;
  localparam int LatNumW  = LatDiffW + 10;
  localparam int LonNumW  = 27;
  localparam int LimDtW   = 32;
  localparam int LatShift = 24;

  localparam logic [MulBW-1:0] MsPerS = MulBW'(1000);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIME_HORIZON    = 3'd0,
    CFG_SPEED_LIMIT     = 3'd1,
    CFG_ACCEL_LIMIT     = 3'd2,
    CFG_CURVATURE_LIMIT = 3'd3,
    CFG_LON_JERK_LIMIT  = 3'd4,
    CFG_LAT_ACCEL_LIMIT = 3'd5,
    CFG_LAT_JERK_LIMIT  = 3'd6
  } cfg_idx_t;

  // Configuration reset values
  localparam logic [TimeW-1:0]  TimeHorizonRst    = 16'd8000;
  localparam logic [LimitW-1:0] SpeedLimitRst     = 15'd7680;
  localparam logic [LimitW-1:0] AccelLimitRst     = 15'd768;
  localparam logic [LimitW-1:0] CurvatureLimitRst = 15'd13107;
  localparam logic [LimitW-1:0] LonJerkLimitRst   = 15'd1280;
  localparam logic [LimitW-1:0] LatAccelLimitRst  = 15'd1024;
  localparam logic [LimitW-1:0] LatJerkLimitRst   = 15'd1280;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_VV     = 7'b0000010,
    ST_LAT    = 7'b0000100,
    ST_LON    = 7'b0001000,
    ST_LONLIM = 7'b0010000,
    ST_LATLIM = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

endpackage

// ===== design/trajectory_limit_checker.sv =====
// Top level of the trajectory limit checker: sequencer, limit checks and result register.
// A point is taken only in idle and steps through VV, LAT, LON, LONLIM, LATLIM and DONE;
// then a last point's result is registered. The single shared multiplier is used in five
// consecutive steps per point (v*v, v*v*kappa, delta accel*1000, two limit*dt products).
// Reset: synchronous active-high rst restores all limits to their defaults, clears
// the previous-point state and the scan flags, and drops any pending result.
module trajectory_limit_checker
  import tlc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgW-1:0]           cfg_data,
  // input point channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [TimeW-1:0]          point_time,
  input  logic signed [SampleW-1:0] speed,
  input  logic signed [SampleW-1:0] accel,
  input  logic signed [SampleW-1:0] curvature,
  input  logic                      last_point,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      feasible
);

  // Configuration registers
  logic [TimeW-1:0]  time_horizon;
  logic [LimitW-1:0] speed_limit;
  logic [LimitW-1:0] accel_limit;
  logic [LimitW-1:0] curvature_limit;
  logic [LimitW-1:0] lon_jerk_limit;
  logic [LimitW-1:0] lat_accel_limit;
  logic [LimitW-1:0] lat_jerk_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_horizon    <= TimeHorizonRst;
      speed_limit     <= SpeedLimitRst;
      accel_limit     <= AccelLimitRst;
      curvature_limit <= CurvatureLimitRst;
      lon_jerk_limit  <= LonJerkLimitRst;
      lat_accel_limit <= LatAccelLimitRst;
      lat_jerk_limit  <= LatJerkLimitRst;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TIME_HORIZON:    time_horizon    <= cfg_data;
        CFG_SPEED_LIMIT:     speed_limit     <= cfg_data[LimitW-1:0];
        CFG_ACCEL_LIMIT:     accel_limit     <= cfg_data[LimitW-1:0];
        CFG_CURVATURE_LIMIT: curvature_limit <= cfg_data[LimitW-1:0];
        CFG_LON_JERK_LIMIT:  lon_jerk_limit  <= cfg_data[LimitW-1:0];
        CFG_LAT_ACCEL_LIMIT: lat_accel_limit <= cfg_data[LimitW-1:0];
        CFG_LAT_JERK_LIMIT:  lat_jerk_limit  <= cfg_data[LimitW-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  state_t state, state_next;

  logic in_take;
  logic finish_hold;
  logic finish;

  // Accept only while the sequencer is idle
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  // Point captured at accept; payload needs no reset
  logic [TimeW-1:0]          cur_time;
  logic signed [SampleW-1:0] cur_speed;
  logic signed [SampleW-1:0] cur_accel;
  logic signed [SampleW-1:0] cur_curv;
  logic                      last_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_time  <= point_time;
      cur_speed <= speed;
      cur_accel <= accel;
      cur_curv  <= curvature;
      last_r    <= last_point;
    end
  end

  // Per-trajectory state
  logic [TimeW-1:0]          prev_time;
  logic signed [SampleW-1:0] prev_speed;
  logic signed [SampleW-1:0] prev_accel;
  logic signed [SampleW-1:0] prev_curvature;
  logic signed [LatW-1:0]    prev_lat;   // v*v*kappa of the previous point
  logic                      have_previous;
  logic                      point_scan_stopped;
  logic                      pair_scan_stopped;
  logic                      violation_seen;

  // Time step; the sign selects the direction of the rate compares
  logic signed [DtW-1:0] dt;
  assign dt = $signed({1'b0, cur_time}) - $signed({1'b0, prev_time});

  // Shared multiplier and its operand select
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;
  logic                    mul_en;
  logic signed [DtW-1:0]   accel_diff;

  assign accel_diff = DtW'(cur_accel) - DtW'(prev_accel);
  assign mul_en     = (state != ST_IDLE) && (state != ST_DONE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_VV: begin
        mul_a = MulAW'(cur_speed);
        mul_b = MulBW'(cur_speed);
      end
      ST_LAT: begin
        // product holds v*v, which fits 31 bits
        mul_a = mul_p[MulAW-1:0];
        mul_b = MulBW'(cur_curv);
      end
      ST_LON: begin
        mul_a = MulAW'(accel_diff);
        mul_b = MsPerS;
      end
      ST_LONLIM: begin
        mul_a = $signed({{(MulAW-LimitW){1'b0}}, lon_jerk_limit});
        mul_b = MulBW'(dt);
      end
      ST_LATLIM: begin
        mul_a = $signed({{(MulAW-LimitW){1'b0}}, lat_jerk_limit});
        mul_b = MulBW'(dt);
      end
      default: ;
    endcase
  end

  tlc_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  // Intermediate results of the pair checks
  logic signed [LatW-1:0]     lat_cur;
  logic signed [LonNumW-1:0]  lon_num;
  logic signed [LatDiffW-1:0] lat_diff;
  logic signed [LatNumW-1:0]  lat_num;
  logic                       lat_over;
  logic                       lon_viol;
  logic signed [LatNumW-1:0]  lat_diff_ext;
  logic signed [LimDtW-1:0]   lon_lim_dt;
  logic signed [LatNumW-1:0]  lat_lim_dt;
  logic                       lat_jerk_viol;

  assign lat_diff_ext = LatNumW'(lat_diff);
  assign lon_lim_dt   = mul_p[LimDtW-1:0];
  // scale limit*dt by 2^24, keeping its sign for a backwards time step
  assign lat_lim_dt   = LatNumW'($signed({mul_p[LimDtW-1:0], {LatShift{1'b0}}}));

  // Rate compare without division: flip when time runs backwards
  assign lat_jerk_viol = dt[DtW-1] ? (lat_num < lat_lim_dt) : (lat_num > lat_lim_dt);

  always_ff @(posedge clk) begin
    case (state)
      ST_LON: begin
        lat_cur <= mul_p[LatW-1:0];
      end
      ST_LONLIM: begin
        lon_num  <= mul_p[LonNumW-1:0];
        lat_diff <= LatDiffW'(lat_cur) - LatDiffW'(prev_lat);
        lat_over <= lat_cur > $signed({{(LatW-LimitW-LatShift){1'b0}}, lat_accel_limit,
                                       {LatShift{1'b0}}});
      end
      ST_LATLIM: begin
        lon_viol <= dt[DtW-1] ? (LimDtW'(lon_num) < lon_lim_dt)
                              : (LimDtW'(lon_num) > lon_lim_dt);
        // times 1000 as 1024 - 32 + 8
        lat_num  <= (lat_diff_ext <<< 10) - (lat_diff_ext <<< 5) + (lat_diff_ext <<< 3);
      end
      default: ;
    endcase
  end

  // Point checks and scan stops, settled in the final step
  logic beyond;
  logic point_viol;
  logic pair_active;
  logic viol_next;

  assign beyond      = cur_time > time_horizon;
  assign point_viol  = (cur_speed > $signed({1'b0, speed_limit})) ||
                       (cur_accel > $signed({1'b0, accel_limit})) ||
                       (cur_curv  > $signed({1'b0, curvature_limit}));
  assign pair_active = have_previous && !pair_scan_stopped && !beyond;
  assign viol_next   = violation_seen ||
                       (!point_scan_stopped && !beyond && point_viol) ||
                       (pair_active && (lat_over || lon_viol || lat_jerk_viol));

  // Hold the last point until the result register is free
  assign finish_hold = (state == ST_DONE) && last_r && out_valid && out_stall;
  assign finish      = (state == ST_DONE) && !finish_hold;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_take) state_next = ST_VV;
      ST_VV:     state_next = ST_LAT;
      ST_LAT:    state_next = ST_LON;
      ST_LON:    state_next = ST_LONLIM;
      ST_LONLIM: state_next = ST_LATLIM;
      ST_LATLIM: state_next = ST_DONE;
      ST_DONE:   if (!finish_hold) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the trajectory state; clear it after the last point
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time          <= '0;
      prev_speed         <= '0;
      prev_accel         <= '0;
      prev_curvature     <= '0;
      prev_lat           <= '0;
      have_previous      <= 1'b0;
      point_scan_stopped <= 1'b0;
      pair_scan_stopped  <= 1'b0;
      violation_seen     <= 1'b0;
    end else if (finish) begin
      if (last_r) begin
        prev_time          <= '0;
        prev_speed         <= '0;
        prev_accel         <= '0;
        prev_curvature     <= '0;
        prev_lat           <= '0;
        have_previous      <= 1'b0;
        point_scan_stopped <= 1'b0;
        pair_scan_stopped  <= 1'b0;
        violation_seen     <= 1'b0;
      end else begin
        prev_time          <= cur_time;
        prev_speed         <= cur_speed;
        prev_accel         <= cur_accel;
        prev_curvature     <= cur_curv;
        prev_lat           <= lat_cur;
        have_previous      <= 1'b1;
        point_scan_stopped <= point_scan_stopped || beyond;
        pair_scan_stopped  <= pair_scan_stopped || (have_previous && beyond);
        violation_seen     <= viol_next;
      end
    end
  end

  // Result register: the next point may start while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish && last_r) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && last_r) begin
      feasible <= !viol_next;
    end
  end

`ifndef ASSERT_OFF
  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_VV))
    else $error("accepted item did not start the sequencer");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state == ST_DONE) && $past(last_r)))
    else $error("result raised without a finished last point");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (finish && last_r) |=> (!have_previous && !violation_seen && !point_scan_stopped))
    else $error("trajectory state not cleared after last point");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(feasible)))
    else $error("pending result lost or overwritten");
`endif

endmodule

// ===== design/tlc_mul.sv =====
// Shared signed multiplier with a registered product.
module tlc_mul
  import tlc_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [MulAW-1:0] op_a,
  input  logic signed [MulBW-1:0] op_b,
  output logic signed [MulPW-1:0] prod
);

  // Hold the product while disabled
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a * op_b;
    end
  end

endmodule
